// File: sv/mrsag_pkg.sv
package mrsag_pkg;

   // field widths at the ports
   localparam int FIELD_ADDR_BITS = 48;
   localparam int COMMAND_BITS = 2;
   localparam int KIND_BITS = 3;
   localparam int STATUS_BITS = 2;
   localparam int ALIGN_BITS = 17;
   localparam int MASK_BITS = 3;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 17;

   // internal address width default and serial digit size
   localparam int ADDR_BITS_DEFAULT = 48;
   localparam int DIGIT_BITS = 4;
   localparam int MIN_DIGITS = 5;

   // commands
   typedef enum logic [COMMAND_BITS-1:0] {
      CMD_OFFER   = 2'd0,
      CMD_NEXT    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_PRESENT = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_VALID = 2'd0,
      ST_NEED  = 2'd1,
      ST_DONE  = 2'd2
   } status_type;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KIND_MASK    = 3'd0,
      CSR_NEED_READ    = 3'd1,
      CSR_NEED_WRITE   = 3'd2,
      CSR_NEED_EXECUTE = 3'd3,
      CSR_STEP_ALIGN   = 3'd4,
      CSR_ACCESS_SIZE  = 3'd5
   } csr_index_type;

   // region kinds
   localparam logic [KIND_BITS-1:0] KIND_STACK = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_HEAP  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_IMAGE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_VVAR  = 3'd4;

   // control to a serial unit
   typedef struct packed {
      logic clear;
      logic step;
   } step_ctrl_type;

   // running carries of the serial add and compare pass
   typedef struct packed {
      logic sum_carry;
      logic size_carry;
      logic end_borrow;
   } add_flags_type;

endpackage

// File: sv/mrsag_mod_unit.sv
module mrsag_mod_unit (
   input  logic                                clock,
   input  mrsag_pkg::step_ctrl_type            ctrl,
   input  logic [mrsag_pkg::DIGIT_BITS-1:0]    digit,
   input  logic [mrsag_pkg::ALIGN_BITS-1:0]    divisor,
   output logic [mrsag_pkg::ALIGN_BITS-1:0]    remainder
);
   import mrsag_pkg::*;

   logic [ALIGN_BITS-1:0] rem_ff;
   logic [ALIGN_BITS-1:0] rem_in;

   // one digit of the dividend per cycle while step is set, msb first, restoring steps
   always_comb begin
      logic [ALIGN_BITS:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < DIGIT_BITS; i++) begin
         r = {r[ALIGN_BITS-1:0], digit[DIGIT_BITS-1-i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
         end
      end
      if (ctrl.clear) begin
         rem_in = '0;
      end else if (ctrl.step) begin
         rem_in = r[ALIGN_BITS-1:0];
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

// File: sv/mrsag_add_unit.sv
module mrsag_add_unit (
   input  logic                                clock,
   input  mrsag_pkg::step_ctrl_type            ctrl,
   input  logic [mrsag_pkg::DIGIT_BITS-1:0]    base_digit,
   input  logic [mrsag_pkg::DIGIT_BITS-1:0]    add_digit,
   input  logic [mrsag_pkg::DIGIT_BITS-1:0]    size_digit,
   input  logic [mrsag_pkg::DIGIT_BITS-1:0]    end_digit,
   output logic [mrsag_pkg::DIGIT_BITS-1:0]    sum_digit,
   output mrsag_pkg::add_flags_type            flags
);
   import mrsag_pkg::*;

   localparam int DW = DIGIT_BITS + 1;

   add_flags_type flags_ff;
   add_flags_type flags_in;
   logic [DW-1:0] s;
   logic [DW-1:0] t;
   logic [DW-1:0] e;

   // sum = base + add, then sum + size, then end - (sum + size), lsb digit first
   always_comb begin
      s = DW'(base_digit) + DW'(add_digit) + DW'(flags_ff.sum_carry);
      t = DW'(s[DIGIT_BITS-1:0]) + DW'(size_digit) + DW'(flags_ff.size_carry);
      e = DW'(end_digit) - DW'(t[DIGIT_BITS-1:0]) - DW'(flags_ff.end_borrow);
      if (ctrl.clear) begin
         flags_in = '0;
      end else if (ctrl.step) begin
         flags_in.sum_carry  = s[DIGIT_BITS];
         flags_in.size_carry = t[DIGIT_BITS];
         flags_in.end_borrow = e[DIGIT_BITS];
      end else begin
         flags_in = flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign sum_digit = s[DIGIT_BITS-1:0];
   assign flags = flags_ff;

endmodule

// File: sv/memory_region_scan_address_generator_unit.sv
// offer of a kept region: from accept to result word, MODULO, ALIGN, SWEEP, FINISH
//   and RESP, where N = max(ceil(ADDR_BITS/4), 5) digits go through MODULO for the
//   serial start modulo alignment, through SWEEP for the serial add and end compare
// next-address request with a region held: SWEEP, FINISH, RESP; other words: RESP
// one word in flight; the next is taken the cycle after the result is registered
// synchronous reset: control registers to defaults, no region held, scan not finished
module memory_region_scan_address_generator_unit #(
   parameter int ADDR_BITS = mrsag_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [mrsag_pkg::COMMAND_BITS-1:0]       req_command,
   input  logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    req_region_start,
   input  logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    req_region_end,
   input  logic [mrsag_pkg::KIND_BITS-1:0]          req_region_kind,
   input  logic                                     req_region_readable,
   input  logic                                     req_region_writable,
   input  logic                                     req_region_executable,
   input  logic                                     req_no_more_regions,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    rsp_address,
   output logic [mrsag_pkg::STATUS_BITS-1:0]        rsp_status,
   // register write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mrsag_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mrsag_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import mrsag_pkg::*;

   localparam int NDIG_RAW = (ADDR_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int NDIG = (NDIG_RAW > MIN_DIGITS) ? NDIG_RAW : MIN_DIGITS;
   localparam int PW = NDIG * DIGIT_BITS;
   localparam int CNT_BITS = $clog2(NDIG);
   localparam logic [PW-1:0] LOW_MASK = PW'({ADDR_BITS{1'b1}});
   localparam logic [PW-1:0] HIGH_MASK = ~LOW_MASK;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MODULO = 6'b000010,
      S_ALIGN  = 6'b000100,
      S_SWEEP  = 6'b001000,
      S_FINISH = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // configuration registers
   logic [MASK_BITS-1:0]  kind_mask_ff, kind_mask_in;
   logic                  need_read_ff, need_read_in;
   logic                  need_write_ff, need_write_in;
   logic                  need_exec_ff, need_exec_in;
   logic [ALIGN_BITS-1:0] step_align_ff, step_align_in;
   logic [ALIGN_BITS-1:0] access_size_ff, access_size_in;

   // scan state
   logic                 finished_ff, finished_in;
   logic                 holding_ff, holding_in;
   logic [ADDR_BITS-1:0] cur_addr_ff, cur_addr_in;
   logic [ADDR_BITS-1:0] cur_end_ff, cur_end_in;
   logic [ADDR_BITS-1:0] req_end_ff, req_end_in;
   logic                 is_offer_ff, is_offer_in;

   // digit shift registers
   logic [PW-1:0] base_sr_ff, base_sr_in;
   logic [PW-1:0] badd_sr_ff, badd_sr_in;
   logic [PW-1:0] size_sr_ff, size_sr_in;
   logic [PW-1:0] end_sr_ff, end_sr_in;

   // pending result and output register
   logic [FIELD_ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   status_type                 res_status_ff, res_status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FIELD_ADDR_BITS-1:0] rsp_address_ff, rsp_address_in;
   status_type                 rsp_status_ff, rsp_status_in;

   step_ctrl_type         mod_ctrl;
   step_ctrl_type         add_ctrl;
   logic [ALIGN_BITS-1:0] align_eff;
   logic [ALIGN_BITS-1:0] remainder;
   logic [ALIGN_BITS-1:0] offset;
   logic [DIGIT_BITS-1:0] sum_digit;
   add_flags_type         add_flags;
   logic                  keep;
   logic                  cnt_last;
   logic                  out_free;

   // start modulo alignment, msb digit first
   mrsag_mod_unit u_mod (
      .clock     (clock),
      .ctrl      (mod_ctrl),
      .digit     (base_sr_ff[PW-1 -: DIGIT_BITS]),
      .divisor   (align_eff),
      .remainder (remainder)
   );

   // address step plus end check, lsb digit first
   mrsag_add_unit u_add (
      .clock      (clock),
      .ctrl       (add_ctrl),
      .base_digit (base_sr_ff[DIGIT_BITS-1:0]),
      .add_digit  (badd_sr_ff[DIGIT_BITS-1:0]),
      .size_digit (size_sr_ff[DIGIT_BITS-1:0]),
      .end_digit  (end_sr_ff[DIGIT_BITS-1:0]),
      .sum_digit  (sum_digit),
      .flags      (add_flags)
   );

   // zero alignment acts as one
   assign align_eff = (step_align_ff == '0) ? ALIGN_BITS'(1) : step_align_ff;
   assign offset = (remainder == '0) ? '0 : align_eff - remainder;
   assign cnt_last = (cnt_ff == CNT_BITS'(NDIG - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // region filter: by kind mask, else by permissions
   always_comb begin
      logic by_kind;
      logic by_perm;
      by_kind = (kind_mask_ff[0] && req_region_kind == KIND_STACK) ||
                (kind_mask_ff[1] && req_region_kind == KIND_HEAP) ||
                (kind_mask_ff[2] && req_region_kind == KIND_IMAGE && req_region_executable);
      by_perm = (kind_mask_ff == '0) &&
                !(need_read_ff && (!req_region_readable || req_region_kind == KIND_VVAR)) &&
                !(need_write_ff && !req_region_writable) &&
                !(need_exec_ff && !req_region_executable);
      keep = by_kind || by_perm;
   end

   // register writes
   always_comb begin
      kind_mask_in   = kind_mask_ff;
      need_read_in   = need_read_ff;
      need_write_in  = need_write_ff;
      need_exec_in   = need_exec_ff;
      step_align_in  = step_align_ff;
      access_size_in = access_size_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KIND_MASK:    kind_mask_in = csr_wdata[MASK_BITS-1:0];
            CSR_NEED_READ:    need_read_in = csr_wdata[0];
            CSR_NEED_WRITE:   need_write_in = csr_wdata[0];
            CSR_NEED_EXECUTE: need_exec_in = csr_wdata[0];
            CSR_STEP_ALIGN:   step_align_in = csr_wdata[ALIGN_BITS-1:0];
            CSR_ACCESS_SIZE:  access_size_in = csr_wdata[ALIGN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      finished_in    = finished_ff;
      holding_in     = holding_ff;
      cur_addr_in    = cur_addr_ff;
      cur_end_in     = cur_end_ff;
      req_end_in     = req_end_ff;
      is_offer_in    = is_offer_ff;
      base_sr_in     = base_sr_ff;
      badd_sr_in     = badd_sr_ff;
      size_sr_in     = size_sr_ff;
      end_sr_in      = end_sr_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      mod_ctrl       = '0;
      add_ctrl       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_addr_in = '0;
               state_in    = S_RESP;
               cnt_in      = '0;
               unique case (cmd_type'(req_command))
                  CMD_RESTART: begin
                     finished_in   = 1'b0;
                     holding_in    = 1'b0;
                     res_status_in = ST_NEED;
                  end
                  CMD_PRESENT: begin
                     if (finished_ff) begin
                        res_status_in = ST_DONE;
                     end else if (holding_ff) begin
                        res_addr_in   = FIELD_ADDR_BITS'(cur_addr_ff);
                        res_status_in = ST_VALID;
                     end else begin
                        res_status_in = ST_NEED;
                     end
                  end
                  CMD_NEXT: begin
                     if (finished_ff) begin
                        res_status_in = ST_DONE;
                     end else if (!holding_ff) begin
                        res_status_in = ST_NEED;
                     end else begin
                        base_sr_in     = PW'(cur_addr_ff);
                        badd_sr_in     = PW'(align_eff);
                        size_sr_in     = PW'(access_size_ff);
                        end_sr_in      = PW'(cur_end_ff);
                        is_offer_in    = 1'b0;
                        add_ctrl.clear = 1'b1;
                        state_in       = S_SWEEP;
                     end
                  end
                  CMD_OFFER: begin
                     if (finished_ff) begin
                        res_status_in = ST_DONE;
                     end else begin
                        holding_in = 1'b0;
                        if (req_no_more_regions) begin
                           finished_in   = 1'b1;
                           res_status_in = ST_DONE;
                        end else if (!keep) begin
                           res_status_in = ST_NEED;
                        end else begin
                           base_sr_in     = PW'(ADDR_BITS'(req_region_start));
                           size_sr_in     = PW'(access_size_ff);
                           end_sr_in      = PW'(ADDR_BITS'(req_region_end));
                           req_end_in     = ADDR_BITS'(req_region_end);
                           is_offer_in    = 1'b1;
                           mod_ctrl.clear = 1'b1;
                           state_in       = S_MODULO;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MODULO: begin
            // rotate left so the start is back in place after the last digit
            mod_ctrl.step = 1'b1;
            base_sr_in    = {base_sr_ff[PW-DIGIT_BITS-1:0], base_sr_ff[PW-1 -: DIGIT_BITS]};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            badd_sr_in     = PW'(offset);
            add_ctrl.clear = 1'b1;
            state_in       = S_SWEEP;
         end
         S_SWEEP: begin
            // sum digits fill the base register from the top
            add_ctrl.step = 1'b1;
            base_sr_in    = {sum_digit, base_sr_ff[PW-1:DIGIT_BITS]};
            badd_sr_in    = {{DIGIT_BITS{1'b0}}, badd_sr_ff[PW-1:DIGIT_BITS]};
            size_sr_in    = {{DIGIT_BITS{1'b0}}, size_sr_ff[PW-1:DIGIT_BITS]};
            end_sr_in     = {{DIGIT_BITS{1'b0}}, end_sr_ff[PW-1:DIGIT_BITS]};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // wrap past the address space, or access runs past the region end
            if (add_flags.sum_carry || (|(base_sr_ff & HIGH_MASK)) ||
                add_flags.size_carry || add_flags.end_borrow) begin
               holding_in    = 1'b0;
               res_addr_in   = '0;
               res_status_in = ST_NEED;
            end else begin
               holding_in    = 1'b1;
               cur_addr_in   = base_sr_ff[ADDR_BITS-1:0];
               if (is_offer_ff) begin
                  cur_end_in = req_end_ff;
               end
               res_addr_in   = FIELD_ADDR_BITS'(base_sr_ff[ADDR_BITS-1:0]);
               res_status_in = ST_VALID;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         kind_mask_ff   <= '0;
         need_read_ff   <= 1'b0;
         need_write_ff  <= 1'b0;
         need_exec_ff   <= 1'b0;
         step_align_ff  <= ALIGN_BITS'(1);
         access_size_ff <= ALIGN_BITS'(1);
         finished_ff    <= 1'b0;
         holding_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         kind_mask_ff   <= kind_mask_in;
         need_read_ff   <= need_read_in;
         need_write_ff  <= need_write_in;
         need_exec_ff   <= need_exec_in;
         step_align_ff  <= step_align_in;
         access_size_ff <= access_size_in;
         finished_ff    <= finished_in;
         holding_ff     <= holding_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_addr_ff    <= cur_addr_in;
      cur_end_ff     <= cur_end_in;
      req_end_ff     <= req_end_in;
      is_offer_ff    <= is_offer_in;
      base_sr_ff     <= base_sr_in;
      badd_sr_ff     <= badd_sr_in;
      size_sr_ff     <= size_sr_in;
      end_sr_ff      <= end_sr_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: tb/mrsag_scan_checker.sv
module mrsag_scan_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [mrsag_pkg::COMMAND_BITS-1:0]       req_command,
   input  logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    req_region_start,
   input  logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    req_region_end,
   input  logic [mrsag_pkg::KIND_BITS-1:0]          req_region_kind,
   input  logic                                     req_region_readable,
   input  logic                                     req_region_writable,
   input  logic                                     req_region_executable,
   input  logic                                     req_no_more_regions,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic [mrsag_pkg::FIELD_ADDR_BITS-1:0]    rsp_address,
   input  logic [mrsag_pkg::STATUS_BITS-1:0]        rsp_status,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [mrsag_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mrsag_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                       mismatches,
   output int                                       answers_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import mrsag_pkg::*;

   localparam int AW = FIELD_ADDR_BITS;

   typedef struct packed {
      logic [AW-1:0] address;
      status_type    status;
   } scan_answer_type;

   // register copy
   logic [MASK_BITS-1:0]  kind_mask;
   logic                  want_read;
   logic                  want_write;
   logic                  want_exec;
   logic [ALIGN_BITS-1:0] stride;
   logic [ALIGN_BITS-1:0] span;

   // scan state
   logic                  scan_finished;
   logic                  scan_started;
   logic                  region_held;
   logic [AW-1:0]         scan_addr;
   logic [AW-1:0]         scan_end;

   scan_answer_type       answers_due[$];
   int                    fault_count = 0;

   assign mismatches = fault_count;

   task automatic report_mismatch(input string what);
      $display("scan check at %0t ns: %s", $time, what);
      fault_count = fault_count + 1;
   endtask

   function automatic scan_answer_type answer(input logic [AW-1:0] addr, input status_type st);
      scan_answer_type a;
      a.address = addr;
      a.status = st;
      return a;
   endfunction

   // access of span bytes at addr would pass the exclusive limit
   function automatic logic beyond_end(input logic [AW-1:0] addr, input logic [AW-1:0] lim);
      if (lim < AW'(span)) return 1'b1;
      return addr > lim - AW'(span);
   endfunction

   function automatic logic region_wanted(input logic [KIND_BITS-1:0] kind,
                                          input logic rd, input logic wr, input logic ex);
      if (kind_mask[0] && kind == KIND_STACK) return 1'b1;
      if (kind_mask[1] && kind == KIND_HEAP) return 1'b1;
      if (kind_mask[2] && kind == KIND_IMAGE && ex) return 1'b1;
      if (kind_mask != '0) return 1'b0;
      // permission filter; readable vvar is refused when read is required
      if (want_read && (!rd || kind == KIND_VVAR)) return 1'b0;
      if (want_write && !wr) return 1'b0;
      if (want_exec && !ex) return 1'b0;
      return 1'b1;
   endfunction

   function automatic scan_answer_type predict_scan_answer(
      input logic [COMMAND_BITS-1:0] cmd,
      input logic [AW-1:0] start, input logic [AW-1:0] lim,
      input logic [KIND_BITS-1:0] kind,
      input logic rd, input logic wr, input logic ex, input logic last);
      logic [ALIGN_BITS-1:0] step;
      logic [ALIGN_BITS-1:0] rem;
      logic [AW:0]           bumped;
      step = (stride == '0) ? ALIGN_BITS'(1) : stride;

      if (cmd == CMD_RESTART) begin
         scan_started = 1'b0;
         scan_finished = 1'b0;
         region_held = 1'b0;
         scan_addr = '0;
         scan_end = '0;
         return answer('0, ST_NEED);
      end
      if (cmd == CMD_PRESENT) begin
         if (scan_finished) return answer('0, ST_DONE);
         if (region_held) return answer(scan_addr, ST_VALID);
         return answer('0, ST_NEED);
      end
      if (scan_finished) return answer('0, ST_DONE);
      scan_started = 1'b1;

      // advance within the held region
      if (cmd == CMD_NEXT) begin
         if (!region_held) return answer('0, ST_NEED);
         bumped = {1'b0, scan_addr} + (AW+1)'(step);
         if (bumped[AW]) begin
            region_held = 1'b0;
            return answer('0, ST_NEED);
         end
         scan_addr = bumped[AW-1:0];
         if (beyond_end(scan_addr, scan_end)) begin
            region_held = 1'b0;
            return answer('0, ST_NEED);
         end
         return answer(scan_addr, ST_VALID);
      end

      // region offer, replaces whatever was held
      region_held = 1'b0;
      if (last) begin
         scan_finished = 1'b1;
         scan_addr = '0;
         return answer('0, ST_DONE);
      end
      if (!region_wanted(kind, rd, wr, ex)) return answer('0, ST_NEED);
      rem = ALIGN_BITS'(start % AW'(step));
      bumped = {1'b0, start} + ((rem == '0) ? '0 : (AW+1)'(step - rem));
      if (bumped[AW]) return answer('0, ST_NEED);
      if (beyond_end(bumped[AW-1:0], lim)) return answer('0, ST_NEED);
      scan_addr = bumped[AW-1:0];
      scan_end = lim;
      region_held = 1'b1;
      return answer(scan_addr, ST_VALID);
   endfunction

   always @(posedge clock) begin
      scan_answer_type due;
      if (reset) begin
         kind_mask = '0;
         want_read = 1'b0;
         want_write = 1'b0;
         want_exec = 1'b0;
         stride = ALIGN_BITS'(1);
         span = ALIGN_BITS'(1);
         scan_started = 1'b0;
         scan_finished = 1'b0;
         region_held = 1'b0;
         scan_addr = '0;
         scan_end = '0;
         answers_due.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_KIND_MASK:    kind_mask = csr_wdata[MASK_BITS-1:0];
               CSR_NEED_READ:    want_read = csr_wdata[0];
               CSR_NEED_WRITE:   want_write = csr_wdata[0];
               CSR_NEED_EXECUTE: want_exec = csr_wdata[0];
               CSR_STEP_ALIGN:   stride = csr_wdata[ALIGN_BITS-1:0];
               CSR_ACCESS_SIZE:  span = csr_wdata[ALIGN_BITS-1:0];
               default: ;
            endcase
         end

         // result words against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("result word with nothing outstanding: status %0d address %h",
                                         rsp_status, rsp_address));
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, due.status));
               end
               if (rsp_address !== due.address) begin
                  report_mismatch($sformatf("address %h, expected %h", rsp_address, due.address));
               end
            end
         end

         // accepted request word
         if (req_valid && !req_stall) begin
            answers_due.push_back(predict_scan_answer(req_command, req_region_start,
               req_region_end, req_region_kind, req_region_readable, req_region_writable,
               req_region_executable, req_no_more_regions));
         end
      end
      answers_outstanding <= answers_due.size();
   end

endmodule

// File: tb/memory_region_scan_address_generator_unit_tb.sv
module memory_region_scan_address_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrsag_pkg::*;

   localparam int AW = FIELD_ADDR_BITS;
   localparam logic [AW-1:0] ADDR_LAST = '1;
   localparam logic [KIND_BITS-1:0] KIND_OTHER = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_UNLISTED = 3'd7;
   localparam logic [ALIGN_BITS-1:0] AMOUNT_MAX = 17'h10000;
   localparam int PHASE_WORDS = 132;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [COMMAND_BITS-1:0]    req_command = CMD_OFFER;
   logic [AW-1:0]              req_region_start = '0;
   logic [AW-1:0]              req_region_end = '0;
   logic [KIND_BITS-1:0]       req_region_kind = '0;
   logic                       req_region_readable = 1'b0;
   logic                       req_region_writable = 1'b0;
   logic                       req_region_executable = 1'b0;
   logic                       req_no_more_regions = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [AW-1:0]              rsp_address;
   logic [STATUS_BITS-1:0]     rsp_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = CSR_KIND_MASK;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   int                         mismatches;
   int                         answers_outstanding;

   // pacing and the register values that shape the regions
   int                         idle_pct = 0;
   int                         stall_pct = 0;
   int                         words_sent = 0;
   logic [MASK_BITS-1:0]       cfg_mask = '0;
   logic                       cfg_read = 1'b0;
   logic                       cfg_write = 1'b0;
   logic                       cfg_exec = 1'b0;
   logic [ALIGN_BITS-1:0]      cfg_align = 17'd1;
   logic [ALIGN_BITS-1:0]      cfg_size = 17'd1;

   memory_region_scan_address_generator_unit dut (.*);

   mrsag_scan_checker scan_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic [AW-1:0] rand48();
      return AW'({$urandom, $urandom});
   endfunction

   function automatic logic [ALIGN_BITS-1:0] pick_amount();
      case ($urandom_range(5))
         0: return '0;
         1: return 17'd1;
         2: return AMOUNT_MAX;
         3: return 17'($urandom_range(1, 64));
         4: return 17'd1 << $urandom_range(16);
         default: return 17'($urandom_range(1, 65536));
      endcase
   endfunction

   task automatic send_word(input cmd_type cmd, input logic [AW-1:0] start,
                            input logic [AW-1:0] lim, input logic [KIND_BITS-1:0] kind,
                            input logic rd, input logic wr, input logic ex, input logic last);
      // optional gap before the word
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_region_start <= start;
      req_region_end <= lim;
      req_region_kind <= kind;
      req_region_readable <= rd;
      req_region_writable <= wr;
      req_region_executable <= ex;
      req_no_more_regions <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // command word with random filler in the ignored fields
   task automatic send_command(input cmd_type cmd, input logic last);
      send_word(cmd, rand48(), rand48(), 3'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), last);
   endtask

   task automatic noise_word();
      send_word(cmd_type'(2'($urandom_range(3))), rand48(), rand48(), 3'($urandom_range(7)),
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom_range(3) == 0);
   endtask

   task automatic offer_region();
      logic [AW-1:0]         start;
      logic [AW-1:0]         lim;
      logic [AW:0]           reach;
      logic [KIND_BITS-1:0]  kind;
      logic [ALIGN_BITS-1:0] a;
      logic                  rd;
      logic                  wr;
      logic                  ex;
      int                    pick;
      a = (cfg_align == '0) ? 17'd1 : cfg_align;
      pick = $urandom_range(9);
      if (pick < 5) start = rand48();
      else if (pick < 7) start = AW'($urandom_range(4096));
      else start = ADDR_LAST - AW'($urandom_range(300000));
      // end sized to hold a handful of steps
      reach = {1'b0, start} + (AW+1)'(cfg_size) + (AW+1)'(a) * (AW+1)'($urandom_range(6))
              + (AW+1)'($urandom_range(32'(a)));
      if ($urandom_range(9) == 0) lim = rand48();
      else if (reach[AW]) lim = ADDR_LAST;
      else lim = reach[AW-1:0];
      rd = 1'($urandom_range(1));
      wr = 1'($urandom_range(1));
      ex = 1'($urandom_range(1));
      kind = 3'($urandom_range(7));
      // mostly regions that pass the filter
      if ($urandom_range(3) != 0) begin
         if (cfg_mask != '0) begin
            do kind = KIND_STACK + 3'($urandom_range(2));
            while (!cfg_mask[kind - KIND_STACK]);
            if (kind == KIND_IMAGE) ex = 1'b1;
         end else begin
            rd = rd | cfg_read;
            wr = wr | cfg_write;
            ex = ex | cfg_exec;
         end
      end
      send_word(CMD_OFFER, start, lim, kind, rd, wr, ex, 1'b0);
   endtask

   task automatic scan_sequence();
      int regions;
      regions = $urandom_range(1, 4);
      send_command(CMD_RESTART, 1'($urandom_range(1)));
      repeat (regions) begin
         offer_region();
         repeat ($urandom_range(8)) send_command(CMD_NEXT, 1'($urandom_range(1)));
         if ($urandom_range(9) == 0) noise_word();
      end
      if ($urandom_range(4) != 0) begin
         send_command(CMD_OFFER, 1'b1);
         if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) noise_word();
      end
   endtask

   // stop sending and let every expected result come back
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_outstanding != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_scan(input logic [MASK_BITS-1:0] mask, input logic rd,
                               input logic wr, input logic ex,
                               input logic [ALIGN_BITS-1:0] align,
                               input logic [ALIGN_BITS-1:0] size);
      cfg_mask = mask;
      cfg_read = rd;
      cfg_write = wr;
      cfg_exec = ex;
      cfg_align = align;
      cfg_size = size;
      write_reg(CSR_KIND_MASK, CSR_DATA_BITS'(mask));
      write_reg(CSR_NEED_READ, CSR_DATA_BITS'(rd));
      write_reg(CSR_NEED_WRITE, CSR_DATA_BITS'(wr));
      write_reg(CSR_NEED_EXECUTE, CSR_DATA_BITS'(ex));
      write_reg(CSR_STEP_ALIGN, align);
      write_reg(CSR_ACCESS_SIZE, size);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_goal;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stride 1, size 1, no filtering
      send_command(CMD_NEXT, 1'b0);
      send_command(CMD_PRESENT, 1'b0);
      send_word(CMD_OFFER, '0, 48'd2, KIND_OTHER, 1'b0, 1'b0, 1'b0, 1'b0);
      send_command(CMD_PRESENT, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_word(CMD_OFFER, ADDR_LAST - AW'(1), ADDR_LAST, KIND_UNLISTED, 1'b1, 1'b1, 1'b1,
                1'b0);
      send_word(CMD_OFFER, 48'd10, 48'd20, KIND_STACK, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(CMD_OFFER, 48'd100, 48'd5, KIND_OTHER, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(CMD_OFFER, ADDR_LAST, ADDR_LAST, KIND_UNLISTED, 1'b1, 1'b1, 1'b1, 1'b1);
      send_command(CMD_NEXT, 1'b0);
      send_command(CMD_PRESENT, 1'b0);
      send_command(CMD_RESTART, 1'b0);
      finish_phase();

      // zero stride and zero size, every permission required
      program_scan('0, 1'b1, 1'b1, 1'b1, '0, '0);
      send_word(CMD_OFFER, 48'd0, 48'd64, KIND_VVAR, 1'b1, 1'b1, 1'b1, 1'b0);
      send_word(CMD_OFFER, 48'd5, 48'd5, KIND_OTHER, 1'b1, 1'b1, 1'b1, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_word(CMD_OFFER, 48'd0, 48'd64, KIND_STACK, 1'b1, 1'b0, 1'b1, 1'b0);
      finish_phase();

      // all three mask kinds selected, stride 0x10000; overflow on rounding and on stepping
      program_scan(3'b111, 1'b0, 1'b0, 1'b0, AMOUNT_MAX, 17'd1);
      send_word(CMD_OFFER, 48'd1, 48'h30000, KIND_IMAGE, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(CMD_OFFER, 48'd1, 48'h30000, KIND_IMAGE, 1'b1, 1'b0, 1'b1, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_word(CMD_OFFER, 48'hFFFF_FFFF_0001, ADDR_LAST, KIND_HEAP, 1'b1, 1'b1, 1'b0, 1'b0);
      send_word(CMD_OFFER, 48'hFFFF_FFFF_0000, ADDR_LAST, KIND_STACK, 1'b1, 1'b1, 1'b0, 1'b0);
      send_command(CMD_NEXT, 1'b0);
      send_word(CMD_OFFER, 48'd0, 48'h40000, KIND_OTHER, 1'b1, 1'b1, 1'b1, 1'b0);
      finish_phase();

      // random scans over several register settings and pacing modes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_scan(3'b111, 1'b0, 1'b0, 1'b0, AMOUNT_MAX, AMOUNT_MAX);
            1: program_scan('0, 1'b1, 1'b1, 1'b1, 17'd1, '0);
            default: program_scan(($urandom_range(1) == 0) ? 3'd0 : 3'($urandom_range(1, 7)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), pick_amount(), pick_amount());
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         phase_goal = words_sent + PHASE_WORDS;
         while (words_sent < phase_goal) begin
            if ($urandom_range(99) < 85) scan_sequence();
            else noise_word();
         end
         finish_phase();
      end

      // drain window for stray result words
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
